// ----- rtl/core/fse_frame_container_validator_assert.svh -----
// assertion macros for the fse frame container validator
`ifndef FSE_FRAME_CONTAINER_VALIDATOR_ASSERT_SVH
`define FSE_FRAME_CONTAINER_VALIDATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcv assertion failed");

// next-cycle implication, checked out of reset
`define FCV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcv assertion failed");

`endif

// ----- rtl/core/fcv_pkg.sv -----
// shared constants, codes and helpers of the fse frame container validator
`timescale 1ns / 1ps

package fcv_pkg;

    // default width of the frame byte counter
    localparam int LEN_BITS_DEFAULT = 48;

    // field widths of the channels
    localparam int BYTE_W       = 8;
    localparam int ERR_W        = 4;
    localparam int FRAME_SIZE_W = 48;
    localparam int RAW_LEN_W    = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    // frame layout
    localparam int HDR_BYTES = 20;
    localparam int BLK_BYTES = 9;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCK_MODE      = 2'd1;

    // register reset values
    localparam logic [31:0] EXPECTED_BLOCK_SIZE_RST = 32'(32 * 1024);
    localparam logic [7:0]  MAX_BLOCK_MODE_RST      = 8'd2;

    // result codes
    localparam logic [ERR_W-1:0] ERR_OK       = 4'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT    = 4'd1;
    localparam logic [ERR_W-1:0] ERR_MAGIC    = 4'd2;
    localparam logic [ERR_W-1:0] ERR_BLKSIZE  = 4'd3;
    localparam logic [ERR_W-1:0] ERR_BLKHDR   = 4'd4;
    localparam logic [ERR_W-1:0] ERR_MODE     = 4'd5;
    localparam logic [ERR_W-1:0] ERR_PAYLOAD  = 4'd6;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 4'd7;
    localparam logic [ERR_W-1:0] ERR_EXTRA    = 4'd8;

    // magic "MFSE", byte by byte
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0: b = 8'h4D;
            2'd1: b = 8'h46;
            2'd2: b = 8'h53;
            2'd3: b = 8'h45;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/fcv_byte_if.sv -----
// input channel: one frame byte per item
`timescale 1ns / 1ps

interface fcv_byte_if;
    logic                       valid;
    logic                       ready;
    logic [fcv_pkg::BYTE_W-1:0] data_byte;
    logic                       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- rtl/core/fcv_result_if.sv -----
// output channel: one result item per frame
`timescale 1ns / 1ps

interface fcv_result_if;
    logic                             valid;
    logic                             ready;
    logic [fcv_pkg::ERR_W-1:0]        error_code;
    logic [fcv_pkg::FRAME_SIZE_W-1:0] frame_size;
    logic [fcv_pkg::RAW_LEN_W-1:0]    unpacked_size;

    modport source (output valid, output error_code, output frame_size,
                    output unpacked_size, input ready);
    modport sink (input valid, input error_code, input frame_size,
                  input unpacked_size, output ready);
endinterface

// ----- rtl/core/fcv_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps

interface fcv_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fcv_pkg::CFG_INDEX_W-1:0] index;
    logic [fcv_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/fse_frame_container_validator.sv -----
// top level of the fse frame container validator
// usage:
//   frame  - input channel, one byte of a compressed frame per item, final_byte
//            set on the last byte of the buffer
//   result - output channel, one item per frame (on its final byte) with
//            error_code, frame_size and unpacked_size; lengths zero on error
//   cfg    - register writes (index 0 expected_block_size, 1 max_block_mode),
//            always ready; the user must write only while the block is idle (not enforced)
// timing:
//   an accepted byte lands in an input register and is parsed in the next cycle
//   unless it is a final byte that waits; the result is registered as that byte
//   is parsed. outside that wait one byte per cycle: between the input and result
//   registers each byte only needs counter updates, one 64-bit add and a few compares
// stalls:
//   a waiting result holds up the next final byte and the input behind it;
//   ordinary bytes ahead of it keep flowing while the result register is full
// reset:
//   rst_n is asynchronous, active low; it clears the frame state, the input
//   and result registers and loads the register reset values (32768, 2)
`timescale 1ns / 1ps
`include "fse_frame_container_validator_assert.svh"

module fse_frame_container_validator #(
    parameter int LEN_BITS = fcv_pkg::LEN_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    fcv_byte_if.sink     frame,
    fcv_result_if.source result,
    fcv_cfg_if.sink      cfg
);

    // parse phase of the current frame
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BLKHDR,
        PH_PAYLOAD,
        PH_TAIL
    } phase_t;

    // configuration registers
    logic [31:0] expected_block_size_reg;
    logic [7:0]  max_block_mode_reg;

    // input register
    logic                       in_valid_reg, in_valid_next;
    logic [fcv_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       final_reg, final_next;

    // frame state
    phase_t                phase_reg, phase_next;
    logic [LEN_BITS-1:0]   byte_count_reg, byte_count_next;
    logic [4:0]            fpos_reg, fpos_next;
    logic [31:0]           fshift_reg, fshift_next;     // block size or block raw size
    logic [7:0]            mode_reg, mode_next;
    logic [63:0]           raw_total_reg, raw_total_next;
    logic [31:0]           blocks_left_reg, blocks_left_next;
    logic [63:0]           raw_sum_reg, raw_sum_next;
    logic [31:0]           payload_left_reg, payload_left_next;
    logic [fcv_pkg::ERR_W-1:0] pend_reg, pend_next;

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic [fcv_pkg::ERR_W-1:0]        err_reg, err_next;
    logic [fcv_pkg::FRAME_SIZE_W-1:0] frame_size_reg, frame_size_next;
    logic [fcv_pkg::RAW_LEN_W-1:0]    raw_len_reg, raw_len_next;

    logic        advance;           // byte in the input register is parsed this cycle
    logic        finish;            // current block ends with this byte
    logic [4:0]  pos_m1;
    logic [31:0] blocks_dec;
    logic [63:0] count_ext;
    logic [fcv_pkg::ERR_W-1:0] err_calc;

    // a final byte waits only if the result register cannot be freed
    assign advance = in_valid_reg && (!final_reg || !out_valid_reg || result.ready);

    assign frame.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.error_code    = err_reg;
    assign result.frame_size    = frame_size_reg;
    assign result.unpacked_size = raw_len_reg;

    assign pos_m1     = fpos_reg - 5'd1;
    assign blocks_dec = blocks_left_reg - 32'd1;

    always_comb
    begin
        in_valid_next     = in_valid_reg;
        byte_next         = byte_reg;
        final_next        = final_reg;
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        fpos_next         = fpos_reg;
        fshift_next       = fshift_reg;
        mode_next         = mode_reg;
        raw_total_next    = raw_total_reg;
        blocks_left_next  = blocks_left_reg;
        raw_sum_next      = raw_sum_reg;
        payload_left_next = payload_left_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        err_next          = err_reg;
        frame_size_next   = frame_size_reg;
        raw_len_next      = raw_len_reg;
        finish            = 1'b0;
        err_calc          = fcv_pkg::ERR_OK;
        count_ext         = '0;

        // input register load
        if (frame.valid && frame.ready)
        begin
            in_valid_next = 1'b1;
            byte_next     = frame.data_byte;
            final_next    = frame.final_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            // saturating byte counter
            if (byte_count_reg != '1)
            begin
                byte_count_next = byte_count_reg + LEN_BITS'(1);
            end

            // after the first error bytes are only counted
            if (pend_reg == fcv_pkg::ERR_OK)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (fpos_reg < 5'd4)
                        begin
                            if (byte_reg != fcv_pkg::magic_byte(fpos_reg[1:0]))
                            begin
                                pend_next = fcv_pkg::ERR_MAGIC;
                            end
                        end
                        else if (fpos_reg < 5'd8)
                        begin
                            fshift_next[{fpos_reg[1:0], 3'b000} +: 8] = byte_reg;
                            if (fpos_reg == 5'd7 && fshift_next != expected_block_size_reg)
                            begin
                                pend_next = fcv_pkg::ERR_BLKSIZE;
                            end
                        end
                        else if (fpos_reg < 5'd16)
                        begin
                            raw_total_next[{fpos_reg[2:0], 3'b000} +: 8] = byte_reg;
                        end
                        else
                        begin
                            blocks_left_next[{fpos_reg[1:0], 3'b000} +: 8] = byte_reg;
                        end
                        fpos_next = fpos_reg + 5'd1;
                        // header complete
                        if (fpos_reg == 5'(fcv_pkg::HDR_BYTES - 1) &&
                            pend_next == fcv_pkg::ERR_OK)
                        begin
                            fpos_next   = '0;
                            fshift_next = '0;
                            if (blocks_left_next == '0)
                            begin
                                // no blocks: raw size must be zero
                                if (raw_total_next != raw_sum_reg)
                                begin
                                    pend_next = fcv_pkg::ERR_MISMATCH;
                                end
                                else
                                begin
                                    phase_next = PH_TAIL;
                                end
                            end
                            else
                            begin
                                phase_next = PH_BLKHDR;
                            end
                        end
                    end
                    PH_BLKHDR:
                    begin
                        if (fpos_reg == 5'd0)
                        begin
                            mode_next = byte_reg;
                        end
                        else if (fpos_reg < 5'd5)
                        begin
                            fshift_next[{pos_m1[1:0], 3'b000} +: 8] = byte_reg;
                        end
                        else
                        begin
                            payload_left_next[{pos_m1[1:0], 3'b000} +: 8] = byte_reg;
                        end
                        fpos_next = fpos_reg + 5'd1;
                        // block header complete
                        if (fpos_reg == 5'(fcv_pkg::BLK_BYTES - 1))
                        begin
                            if (mode_next > max_block_mode_reg)
                            begin
                                pend_next = fcv_pkg::ERR_MODE;
                            end
                            else
                            begin
                                raw_sum_next = raw_sum_reg + 64'(fshift_next);
                                if (payload_left_next == '0)
                                begin
                                    finish = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        payload_left_next = payload_left_reg - 32'd1;
                        if (payload_left_next == '0)
                        begin
                            finish = 1'b1;
                        end
                    end
                    PH_TAIL:
                    begin
                        pend_next = fcv_pkg::ERR_EXTRA;
                    end
                endcase

                // end of a block
                if (finish)
                begin
                    blocks_left_next = blocks_dec;
                    if (blocks_dec == '0)
                    begin
                        if (raw_sum_next != raw_total_reg)
                        begin
                            pend_next = fcv_pkg::ERR_MISMATCH;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    else
                    begin
                        phase_next  = PH_BLKHDR;
                        fpos_next   = '0;
                        fshift_next = '0;
                        mode_next   = '0;
                    end
                end
            end

            // final byte: build the result and clear the frame state
            if (final_reg)
            begin
                priority if (byte_count_next < LEN_BITS'(fcv_pkg::HDR_BYTES))
                begin
                    err_calc = fcv_pkg::ERR_SHORT;
                end
                else if (pend_next != fcv_pkg::ERR_OK)
                begin
                    err_calc = pend_next;
                end
                else if (phase_next == PH_BLKHDR)
                begin
                    err_calc = fcv_pkg::ERR_BLKHDR;
                end
                else if (phase_next == PH_PAYLOAD)
                begin
                    err_calc = fcv_pkg::ERR_PAYLOAD;
                end
                else
                begin
                    err_calc = fcv_pkg::ERR_OK;
                end

                count_ext       = 64'(byte_count_next);
                out_valid_next  = 1'b1;
                err_next        = err_calc;
                frame_size_next = (err_calc == fcv_pkg::ERR_OK) ?
                                  count_ext[fcv_pkg::FRAME_SIZE_W-1:0] : '0;
                raw_len_next    = (err_calc == fcv_pkg::ERR_OK) ? raw_total_next : '0;

                phase_next        = PH_HEADER;
                byte_count_next   = '0;
                fpos_next         = '0;
                fshift_next       = '0;
                mode_next         = '0;
                raw_total_next    = '0;
                blocks_left_next  = '0;
                raw_sum_next      = '0;
                payload_left_next = '0;
                pend_next         = fcv_pkg::ERR_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_block_size_reg <= fcv_pkg::EXPECTED_BLOCK_SIZE_RST;
            max_block_mode_reg      <= fcv_pkg::MAX_BLOCK_MODE_RST;
            in_valid_reg            <= 1'b0;
            byte_reg                <= '0;
            final_reg               <= 1'b0;
            phase_reg               <= PH_HEADER;
            byte_count_reg          <= '0;
            fpos_reg                <= '0;
            fshift_reg              <= '0;
            mode_reg                <= '0;
            raw_total_reg           <= '0;
            blocks_left_reg         <= '0;
            raw_sum_reg             <= '0;
            payload_left_reg        <= '0;
            pend_reg                <= fcv_pkg::ERR_OK;
            out_valid_reg           <= 1'b0;
            err_reg                 <= fcv_pkg::ERR_OK;
            frame_size_reg          <= '0;
            raw_len_reg             <= '0;
        end
        else
        begin
            // register writes; indexes beyond the list are dropped
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == fcv_pkg::REG_EXPECTED_BLOCK_SIZE)
                begin
                    expected_block_size_reg <= cfg.data;
                end
                else if (cfg.index == fcv_pkg::REG_MAX_BLOCK_MODE)
                begin
                    max_block_mode_reg <= cfg.data[7:0];
                end
            end
            in_valid_reg     <= in_valid_next;
            byte_reg         <= byte_next;
            final_reg        <= final_next;
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            fpos_reg         <= fpos_next;
            fshift_reg       <= fshift_next;
            mode_reg         <= mode_next;
            raw_total_reg    <= raw_total_next;
            blocks_left_reg  <= blocks_left_next;
            raw_sum_reg      <= raw_sum_next;
            payload_left_reg <= payload_left_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
            err_reg          <= err_next;
            frame_size_reg   <= frame_size_next;
            raw_len_reg      <= raw_len_next;
        end
    end

    // a parsed final byte leaves a result and a cleared frame behind
    `FCV_ASSERT_NEXT(a_final_clears, advance && final_reg, out_valid_reg && phase_reg == PH_HEADER && byte_count_reg == '0)
    // lengths are zero on every error result
    `FCV_ASSERT_NOW(a_err_zero_len, out_valid_reg && err_reg != fcv_pkg::ERR_OK, frame_size_reg == '0 && raw_len_reg == '0)
    // a good frame holds at least a full header
    `FCV_ASSERT_NOW(a_ok_min_len, out_valid_reg && err_reg == fcv_pkg::ERR_OK, frame_size_reg >= 48'(fcv_pkg::HDR_BYTES))
    // the tail is only reached with all blocks done
    `FCV_ASSERT_NOW(a_tail_no_blocks, phase_reg == PH_TAIL, blocks_left_reg == '0)

endmodule

// ----- verif/fse_frame_container_validator_test.sv -----
// self-checking testbench of the fse frame container validator, with a frame scanner of its own
`timescale 1ns / 1ps

module fse_frame_container_validator_test;

    // run length guard, far above the slowest correct run
    localparam int CYCLE_LIMIT  = 500_000;
    // cycles allowed after the last result before the block counts as idle
    localparam int DRAIN_CYCLES = 8;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    // "MFSE" in wire order, first byte in the low bits
    localparam logic [31:0] MAGIC_LE = 32'h4553_464D;

    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_BLOCK_HDR,
        SCAN_PAYLOAD,
        SCAN_TRAILER
    } scan_phase_t;

    typedef struct packed {
        logic [fcv_pkg::ERR_W-1:0]        code;
        logic [fcv_pkg::FRAME_SIZE_W-1:0] frame_size;
        logic [fcv_pkg::RAW_LEN_W-1:0]    raw_len;
    } frame_verdict_t;

    logic clk;
    logic rst_n;

    fcv_byte_if   frame_ch();
    fcv_result_if verdict_ch();
    fcv_cfg_if    cfg_ch();

    fse_frame_container_validator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (verdict_ch),
        .cfg    (cfg_ch)
    );

    // our copy of the two registers
    logic [31:0] cfg_block_size;
    logic [7:0]  cfg_max_mode;

    // frame scan state, cleared after every final byte
    scan_phase_t                      scan_phase;
    logic [fcv_pkg::FRAME_SIZE_W-1:0] seen_bytes;
    logic [4:0]                       field_idx;
    logic [63:0]                      field_acc;      // block size, or block raw size plus mode at 39:32
    logic [63:0]                      hdr_raw_bytes;
    logic [31:0]                      blocks_left;
    logic [63:0]                      block_raw_sum;
    logic [31:0]                      payload_left;
    logic [fcv_pkg::ERR_W-1:0]        first_error;

    frame_verdict_t verdicts_due[$];        // results still owed by the block, oldest first
    logic [7:0]     frame_bytes[$];         // frame under construction

    int fail_count;
    int cycle_count;
    int bytes_taken;
    int frames_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold;

    // ------------------------------------------------------------------
    // frame scanner: expected verdict of each frame
    // ------------------------------------------------------------------

    function automatic void clear_scan();
        scan_phase    = SCAN_HEADER;
        seen_bytes    = '0;
        field_idx     = '0;
        field_acc     = '0;
        hdr_raw_bytes = '0;
        blocks_left   = '0;
        block_raw_sum = '0;
        payload_left  = '0;
        first_error   = fcv_pkg::ERR_OK;
    endfunction

    // only the first error of a frame sticks
    function automatic void note_error(input logic [fcv_pkg::ERR_W-1:0] code);
        if (first_error == fcv_pkg::ERR_OK)
            first_error = code;
    endfunction

    // all blocks seen: raw sizes must add up to the frame header's raw size
    function automatic void close_block_list();
        if (block_raw_sum != hdr_raw_bytes)
            note_error(fcv_pkg::ERR_MISMATCH);
        else
            scan_phase = SCAN_TRAILER;
    endfunction

    function automatic void finish_block();
        blocks_left--;
        if (blocks_left == 0)
            close_block_list();
        else
        begin
            scan_phase = SCAN_BLOCK_HDR;
            field_idx  = '0;
            field_acc  = '0;
        end
    endfunction

    function automatic void take_frame_byte(input logic [7:0] b, input logic last);
        int                        p;
        logic [fcv_pkg::ERR_W-1:0] code;
        p = field_idx;
        if (seen_bytes != '1)
            seen_bytes++;
        // after an error, bytes are only counted
        if (first_error == fcv_pkg::ERR_OK)
        begin
            case (scan_phase)
                SCAN_HEADER:
                begin
                    if (p < 4)
                    begin
                        if (b != MAGIC_LE[8*p +: 8])
                            note_error(fcv_pkg::ERR_MAGIC);
                    end
                    else if (p < 8)
                    begin
                        field_acc |= 64'(b) << (8 * (p - 4));
                        if (p == 7 && field_acc[31:0] != cfg_block_size)
                            note_error(fcv_pkg::ERR_BLKSIZE);
                    end
                    else if (p < 16)
                        hdr_raw_bytes |= 64'(b) << (8 * (p - 8));
                    else
                        blocks_left |= 32'(b) << (8 * (p - 16));
                    field_idx = 5'(p + 1);
                    if (field_idx == fcv_pkg::HDR_BYTES && first_error == fcv_pkg::ERR_OK)
                    begin
                        field_idx = '0;
                        field_acc = '0;
                        // a frame with no blocks is checked right here
                        if (blocks_left == 0)
                            close_block_list();
                        else
                            scan_phase = SCAN_BLOCK_HDR;
                    end
                end
                SCAN_BLOCK_HDR:
                begin
                    if (p == 0)
                        field_acc |= 64'(b) << 32;
                    else if (p < 5)
                        field_acc |= 64'(b) << (8 * (p - 1));
                    else
                        payload_left |= 32'(b) << (8 * (p - 5));
                    field_idx = 5'(p + 1);
                    // mode is judged only once the block header is complete
                    if (field_idx == fcv_pkg::BLK_BYTES)
                    begin
                        if (field_acc[39:32] > cfg_max_mode)
                            note_error(fcv_pkg::ERR_MODE);
                        else
                        begin
                            block_raw_sum += 64'(field_acc[31:0]);
                            if (payload_left == 0)
                                finish_block();
                            else
                                scan_phase = SCAN_PAYLOAD;
                        end
                    end
                end
                SCAN_PAYLOAD:
                begin
                    payload_left--;
                    if (payload_left == 0)
                        finish_block();
                end
                default:
                    note_error(fcv_pkg::ERR_EXTRA);
            endcase
        end
        if (last)
        begin
            if (seen_bytes < fcv_pkg::HDR_BYTES)
                code = fcv_pkg::ERR_SHORT;
            else if (first_error != fcv_pkg::ERR_OK)
                code = first_error;
            else if (scan_phase == SCAN_BLOCK_HDR)
                code = fcv_pkg::ERR_BLKHDR;
            else if (scan_phase == SCAN_PAYLOAD)
                code = fcv_pkg::ERR_PAYLOAD;
            else
                code = fcv_pkg::ERR_OK;
            verdicts_due.push_back('{code,
                                     (code == fcv_pkg::ERR_OK) ? seen_bytes : '0,
                                     (code == fcv_pkg::ERR_OK) ? hdr_raw_bytes : '0});
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // frame construction
    // ------------------------------------------------------------------

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_frame_header(input logic [31:0] blk_size,
                                             input logic [63:0] raw_bytes,
                                             input logic [31:0] count);
        put_le(64'(MAGIC_LE), 4);
        put_le(64'(blk_size), 4);
        put_le(raw_bytes, 8);
        put_le(64'(count), 4);
    endfunction

    // block header plus stored bytes of random payload
    function automatic void put_block(input logic [7:0] mode, input logic [31:0] raw_bytes,
                                      input int stored);
        frame_bytes.push_back(mode);
        put_le(64'(raw_bytes), 4);
        put_le(64'(stored), 4);
        repeat (stored)
            frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic void trim_frame(input int n);
        while (frame_bytes.size() > n)
            void'(frame_bytes.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // offer one item, with random sender gaps before it, and wait until it is taken
    task automatic send_frame_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_ch.valid = 1'b0;
            @(negedge clk);
        end
        frame_ch.valid      = 1'b1;
        frame_ch.data_byte  = b;
        frame_ch.final_byte = last;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        take_frame_byte(b, last);
        bytes_taken++;
    endtask

    // send the frame under construction, final flag on its last byte
    task automatic send_frame();
        foreach (frame_bytes[i])
            send_frame_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    // sender goes quiet until every owed result is in, then lets the block settle
    task automatic wait_for_verdicts();
        @(negedge clk);
        frame_ch.valid      = 1'b0;
        frame_ch.final_byte = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [fcv_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == fcv_pkg::REG_EXPECTED_BLOCK_SIZE)
            cfg_block_size = value;
        else if (idx == fcv_pkg::REG_MAX_BLOCK_MODE)
            cfg_max_mode = value[7:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one frame per error code and corner, with the reset register values
    task automatic test_directed_frames();
        // a lone byte can only be too short
        frame_bytes.push_back(8'hFF);
        send_frame();
        // bad magic but under header length: too short wins
        put_frame_header(cfg_block_size, 64'd0, 32'd0);
        frame_bytes[0] = 8'h00;
        trim_frame(fcv_pkg::HDR_BYTES - 1);
        send_frame();
        // empty frame, no blocks and zero raw size
        put_frame_header(cfg_block_size, 64'd0, 32'd0);
        send_frame();
        // no blocks but a raw size: mismatch right after the header
        put_frame_header(cfg_block_size, 64'd5, 32'd0);
        send_frame();
        // magic wrong in its last byte, rest of the frame fine
        put_frame_header(cfg_block_size, 64'd10, 32'd1);
        put_block(8'd0, 32'd10, 0);
        frame_bytes[3] = 8'h00;
        send_frame();
        // block size off by one
        put_frame_header(cfg_block_size - 32'd1, 64'd0, 32'd0);
        send_frame();
        // ends inside a block header
        put_frame_header(cfg_block_size, 64'd7, 32'd1);
        put_block(8'd1, 32'd7, 2);
        trim_frame(fcv_pkg::HDR_BYTES + 5);
        send_frame();
        // ends right after the frame header with a block announced
        put_frame_header(cfg_block_size, 64'd0, 32'd1);
        send_frame();
        // mode one above the limit, trailing bytes only counted
        put_frame_header(cfg_block_size, 64'd7, 32'd1);
        put_block(cfg_max_mode + 8'd1, 32'd7, 2);
        frame_bytes.push_back(8'h5A);
        send_frame();
        // ends inside the payload
        put_frame_header(cfg_block_size, 64'd7, 32'd1);
        put_block(cfg_max_mode, 32'd7, 4);
        trim_frame(frame_bytes.size() - 2);
        send_frame();
        // good frame followed by an extra byte
        put_frame_header(cfg_block_size, 64'd10, 32'd1);
        put_block(8'd0, 32'd10, 0);
        frame_bytes.push_back(8'h00);
        send_frame();
        // two blocks, raw sum carries past 32 bits
        put_frame_header(cfg_block_size, 64'h1_0000_0000, 32'd2);
        put_block(cfg_max_mode, 32'hFFFF_FFFF, 3);
        put_block(8'd0, 32'd1, 0);
        send_frame();
        // raw sum off and extra bytes: mismatch comes first
        put_frame_header(cfg_block_size, 64'd12, 32'd2);
        put_block(8'd1, 32'd5, 1);
        put_block(8'd1, 32'd6, 0);
        frame_bytes.push_back(8'hAA);
        send_frame();
    endtask

    // both registers at their extremes
    task automatic test_register_extremes();
        logic [31:0] size_of[2];
        logic [7:0]  mode_lim[2];
        size_of  = '{32'd1, 32'hFFFF_FFFF};
        mode_lim = '{8'd0, 8'hFF};
        for (int k = 0; k < 2; k++)
        begin
            wait_for_verdicts();
            write_register(fcv_pkg::REG_EXPECTED_BLOCK_SIZE, size_of[k]);
            // upper data bits are junk, only the low byte counts
            write_register(fcv_pkg::REG_MAX_BLOCK_MODE, {24'($urandom), mode_lim[k]});
            // highest accepted mode
            put_frame_header(cfg_block_size, 64'd3, 32'd1);
            put_block(cfg_max_mode, 32'd3, 1);
            send_frame();
            // block size differs in bit 0
            put_frame_header(cfg_block_size ^ 32'd1, 64'd0, 32'd0);
            send_frame();
            // one above the mode limit, where there is one
            if (cfg_max_mode != 8'hFF)
            begin
                put_frame_header(cfg_block_size, 64'd3, 32'd1);
                put_block(cfg_max_mode + 8'd1, 32'd3, 0);
                send_frame();
            end
        end
    endtask

    // half of the frames well-formed with random content, the rest corrupted or noise
    task automatic send_random_frame();
        logic [31:0] raw_of[3];
        int          stored_of[3];
        logic [7:0]  mode_of[3];
        int          hdr_at[$];
        logic [63:0] raw_total;
        int          nblk;
        int          roll;
        raw_total = '0;
        nblk = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
        for (int i = 0; i < nblk; i++)
        begin
            raw_of[i]    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
            stored_of[i] = ($urandom_range(15) == 0) ? $urandom_range(40, 6) : $urandom_range(4);
            mode_of[i]   = 8'($urandom_range(cfg_max_mode));
            raw_total   += 64'(raw_of[i]);
        end
        put_frame_header(cfg_block_size, raw_total, 32'(nblk));
        for (int i = 0; i < nblk; i++)
        begin
            hdr_at.push_back(frame_bytes.size());
            put_block(mode_of[i], raw_of[i], stored_of[i]);
        end

        roll = $urandom_range(99);
        if (roll < 50)
            ;   // left well-formed
        else if (roll < 56)
            trim_frame($urandom_range(fcv_pkg::HDR_BYTES - 1, 1));
        else if (roll < 62)
            frame_bytes[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
        else if (roll < 68)
            frame_bytes[$urandom_range(7, 4)] ^= 8'($urandom_range(255, 1));
        else if (roll < 76 && frame_bytes.size() > fcv_pkg::HDR_BYTES + 1)
            trim_frame($urandom_range(frame_bytes.size() - 1, fcv_pkg::HDR_BYTES + 1));
        else if (roll < 82 && nblk > 0 && cfg_max_mode != 8'hFF)
            frame_bytes[hdr_at[$urandom_range(nblk - 1)]] =
                8'($urandom_range(255, cfg_max_mode + 1));
        else if (roll < 88)
            frame_bytes[$urandom_range(15, 8)] ^= 8'($urandom_range(255, 1));
        else if (roll < 94)
            repeat ($urandom_range(3, 1))
                frame_bytes.push_back(8'($urandom));
        else if (roll < 97 && frame_bytes.size() > fcv_pkg::HDR_BYTES)
            // hit anything in the block area: mode, sizes or payload
            frame_bytes[$urandom_range(frame_bytes.size() - 1, fcv_pkg::HDR_BYTES)] ^=
                8'($urandom_range(255, 1));
        else
        begin
            // plain noise, sometimes behind a valid magic
            frame_bytes.delete();
            if ($urandom_range(1) == 0)
                put_le(64'(MAGIC_LE), 4);
            repeat ($urandom_range(45, 1))
                frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // random frames under each idling profile, fresh register values per profile
    task automatic test_random_frames();
        int idle_of[4];
        int stall_of[4];
        int b0;
        idle_of  = '{0, 87, 0, 11};
        stall_of = '{0, 0, 87, 11};
        for (int k = 0; k < 4; k++)
        begin
            wait_for_verdicts();
            write_register(fcv_pkg::REG_EXPECTED_BLOCK_SIZE, ($urandom_range(1) == 0) ?
                           fcv_pkg::EXPECTED_BLOCK_SIZE_RST : $urandom_range(32'hFFFF_FFFF, 1));
            write_register(fcv_pkg::REG_MAX_BLOCK_MODE, 32'($urandom_range(255)));
            send_idle_pct  = idle_of[k];
            recv_stall_pct = stall_of[k];
            b0 = bytes_taken;
            while (bytes_taken - b0 < 24)
                send_random_frame();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // long receiver hold-off with the sender still pushing, so final bytes back up
    task automatic test_input_backpressure();
        wait_for_verdicts();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        recv_hold = HOLD_CYCLES;
        repeat (8)
        begin
            if ($urandom_range(2) == 0)
                put_frame_header(cfg_block_size, 64'd0, 32'd0);
            else
                repeat ($urandom_range(3, 1))
                    frame_bytes.push_back(8'($urandom));
            send_frame();
        end
        // sender holds off until the backed-up results are all out
        wait_for_verdicts();
        recv_stall_pct = 50;
        repeat (2)
            send_random_frame();
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // clock, receiver, checker, guard
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold--;
            verdict_ch.ready = 1'b0;
        end
        else
            verdict_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // every taken result against the oldest owed one
    always @(posedge clk)
    begin
        frame_verdict_t due;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with nothing owed: code %0d frame_size %0d raw_len %0d",
                         $time, verdict_ch.error_code, verdict_ch.frame_size,
                         verdict_ch.unpacked_size);
                fail_count++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (verdict_ch.error_code !== due.code)
                begin
                    $display("%0t: error_code expected %0d, actual %0d",
                             $time, due.code, verdict_ch.error_code);
                    fail_count++;
                end
                if (verdict_ch.frame_size !== due.frame_size)
                begin
                    $display("%0t: frame_size expected %0d, actual %0d",
                             $time, due.frame_size, verdict_ch.frame_size);
                    fail_count++;
                end
                if (verdict_ch.unpacked_size !== due.raw_len)
                begin
                    $display("%0t: unpacked_size expected %0d, actual %0d",
                             $time, due.raw_len, verdict_ch.unpacked_size);
                    fail_count++;
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results owed",
                     $time, cycle_count, verdicts_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        frame_ch.valid      = 1'b0;
        frame_ch.data_byte  = '0;
        frame_ch.final_byte = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = fcv_pkg::REG_EXPECTED_BLOCK_SIZE;
        cfg_ch.data         = '0;
        verdict_ch.ready    = 1'b0;
        cfg_block_size      = fcv_pkg::EXPECTED_BLOCK_SIZE_RST;
        cfg_max_mode        = fcv_pkg::MAX_BLOCK_MODE_RST;
        clear_scan();
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_register_extremes();
        test_random_frames();
        test_input_backpressure();
        wait_for_verdicts();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
